// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers for the RTL core file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error("assertion failed");

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== hw/rtl/fptc_pkg.sv =====
package fptc_pkg;

    localparam int TEMP_W  = 9;
    localparam int ON_W    = 7;
    localparam int DUTY_W  = 9;
    localparam int KICK_W  = 14;
    localparam int PHASE_W = 9;
    localparam int DIV_W   = 9;
    localparam int DELTA_W = 8;
    localparam int NUM_W   = DELTA_W + DUTY_W;
    localparam int DCNT_W  = $clog2(NUM_W + 1);
    localparam int K_W     = 3;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = ON_W;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [CFG_IDX_W-1:0] CFG_FAN_ON_TEMP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FAN_MODE    = 2'd1;

    localparam logic [ON_W-1:0] ON_TEMP_RESET  = 7'd30;
    localparam logic            FAN_MODE_RESET = 1'b1;

    localparam logic [DUTY_W-1:0] PWM_PERIOD = 9'd300;
    localparam logic [KICK_W-1:0] KICK_TICKS = 14'd10000;
    localparam logic [DUTY_W-1:0] MIN_DUTY   = 9'd30;

    localparam logic signed [TEMP_W-1:0] BAND_40 = 9'sd40;
    localparam logic signed [TEMP_W-1:0] BAND_50 = 9'sd50;
    localparam logic signed [TEMP_W-1:0] BAND_60 = 9'sd60;

    localparam logic [K_W-1:0] K_BELOW_40 = 3'd4;
    localparam logic [K_W-1:0] K_40_49    = 3'd3;
    localparam logic [K_W-1:0] K_50_59    = 3'd2;
    localparam logic [K_W-1:0] K_60_UP    = 3'd1;

    typedef enum logic [1:0] {
        CLS_COLD,
        CLS_FULL,
        CLS_PWM
    } t_item_class;

    typedef struct packed {
        t_item_class             cls;
        logic signed [TEMP_W-1:0] temperature;
        logic                    high_power;
        logic [ON_W-1:0]         on_temp;
    } t_queue_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT
    } t_back_state;

endpackage

// ===== hw/rtl/fptc_front.sv =====
module fptc_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic signed [fptc_pkg::TEMP_W-1:0] i_temperature,
    input  logic                              i_high_power,
    input  logic                              i_cfg_we,
    input  logic [fptc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [fptc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_queue_full,
    output logic                              o_push,
    output fptc_pkg::t_queue_item             o_item
);
    import fptc_pkg::*;

    logic [ON_W-1:0] r_on_temp;
    logic            r_fan_mode;
    logic            cold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on_temp  <= ON_TEMP_RESET;
            r_fan_mode <= FAN_MODE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FAN_ON_TEMP: r_on_temp  <= i_cfg_data[ON_W-1:0];
                CFG_FAN_MODE:    r_fan_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign cold    = i_temperature < $signed({{(TEMP_W-ON_W){1'b0}}, r_on_temp});
    assign o_stall = i_queue_full;
    assign o_push  = i_valid && !i_queue_full;

    always_comb begin
        o_item.temperature = i_temperature;
        o_item.high_power  = i_high_power;
        o_item.on_temp     = r_on_temp;
        if (cold) begin
            o_item.cls = CLS_COLD;
        end else if (r_fan_mode) begin
            o_item.cls = CLS_FULL;
        end else begin
            o_item.cls = CLS_PWM;
        end
    end

endmodule

// ===== hw/rtl/fptc_queue.sv =====
module fptc_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  fptc_pkg::t_queue_item i_item,
    output logic                  o_full,
    output logic                  o_valid,
    output fptc_pkg::t_queue_item o_item,
    input  logic                  i_pop
);
    import fptc_pkg::*;

    t_queue_item       r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = r_count == (QPTR_W + 1)'(QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_item  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/fptc_back.sv =====
module fptc_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_q_valid,
    input  fptc_pkg::t_queue_item          i_q_item,
    output logic                           o_pop,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic                           o_fan_level,
    output logic [fptc_pkg::DUTY_W-1:0]    o_duty_ticks,
    output logic                           o_kicking
);
    import fptc_pkg::*;

    t_back_state        r_state;
    t_back_state        n_state;
    t_queue_item        r_item;
    logic [NUM_W-1:0]   r_num;
    logic [DIV_W-1:0]   r_rem;
    logic [DIV_W-1:0]   r_div;
    logic [DCNT_W-1:0]  r_cnt;
    logic [DUTY_W-1:0]  r_duty;

    logic               r_pwm_running;
    logic               r_kick_pending;
    logic [KICK_W-1:0]  r_kick_cnt;
    logic [PHASE_W-1:0] r_phase;
    logic [DUTY_W-1:0]  r_mark;
    logic               r_last_hp;

    logic               n_pwm_running;
    logic               n_kick_pending;
    logic [KICK_W-1:0]  n_kick_cnt;
    logic [PHASE_W-1:0] n_phase;
    logic [DUTY_W-1:0]  n_mark;
    logic               n_last_hp;
    logic               n_level;
    logic               n_kick;
    logic [DUTY_W-1:0]  n_duty_out;

    logic               r_out_valid;
    logic               r_out_level;
    logic [DUTY_W-1:0]  r_out_duty;
    logic               r_out_kick;

    logic               out_free;
    logic               load_out;
    logic               div_step;
    logic               start_div;

    logic [DELTA_W-1:0] delta;
    logic [K_W-1:0]     k_sel;
    logic [ON_W+K_W-1:0] div_prod;
    logic [DIV_W:0]     rem_sh;
    logic               rem_ge;
    logic [DIV_W:0]     rem_nx;
    logic [NUM_W-1:0]   quo_nx;
    logic [DUTY_W-1:0]  quo_clamped;
    logic [PHASE_W:0]   phase_sum;

    assign out_free = !r_out_valid || !i_stall;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    if (i_q_item.cls == CLS_PWM && i_q_item.on_temp != '0) begin
                        n_state = ST_DIV;
                    end else begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_DIV: begin
                if (r_cnt == DCNT_W'(1)) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        o_pop     = 1'b0;
        load_out  = 1'b0;
        div_step  = 1'b0;
        start_div = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_pop     = i_q_valid;
                start_div = i_q_valid;
            end
            ST_DIV:  div_step = 1'b1;
            ST_EMIT: load_out = out_free;
            default: ;
        endcase
    end

    always_comb begin
        delta = i_q_item.temperature[DELTA_W-1:0] - DELTA_W'(i_q_item.on_temp);
        if (i_q_item.temperature < BAND_40) begin
            k_sel = K_BELOW_40;
        end else if (i_q_item.temperature < BAND_50) begin
            k_sel = K_40_49;
        end else if (i_q_item.temperature < BAND_60) begin
            k_sel = K_50_59;
        end else begin
            k_sel = K_60_UP;
        end
        div_prod = (ON_W + K_W)'(i_q_item.on_temp) * (ON_W + K_W)'(k_sel);
    end

    always_comb begin
        rem_sh = {r_rem, r_num[NUM_W-1]};
        rem_ge = rem_sh >= {1'b0, r_div};
        rem_nx = rem_ge ? rem_sh - {1'b0, r_div} : rem_sh;
        quo_nx = {r_num[NUM_W-2:0], rem_ge};
        quo_clamped = DUTY_W'(quo_nx);
        if (quo_nx <= NUM_W'(MIN_DUTY)) begin
            quo_clamped = MIN_DUTY;
        end
        if (NUM_W'(quo_clamped) >= NUM_W'(PWM_PERIOD) || quo_nx >= NUM_W'(PWM_PERIOD)) begin
            quo_clamped = PWM_PERIOD;
        end
    end

    // Tick update for the item being emitted.
    always_comb begin
        n_pwm_running  = r_pwm_running;
        n_kick_pending = r_kick_pending;
        n_kick_cnt     = r_kick_cnt;
        n_phase        = r_phase;
        n_mark         = r_mark;
        n_last_hp      = r_last_hp;
        n_level        = 1'b0;
        n_kick         = 1'b0;
        n_duty_out     = '0;
        phase_sum      = '0;
        case (r_item.cls)
            CLS_COLD: begin
                n_pwm_running  = 1'b0;
                n_kick_pending = 1'b1;
                n_kick_cnt     = '0;
                n_phase        = '0;
            end
            CLS_FULL: begin
                n_last_hp      = r_item.high_power;
                n_pwm_running  = 1'b0;
                n_kick_pending = 1'b1;
                n_level        = 1'b1;
            end
            default: begin
                n_last_hp = r_item.high_power;
                if (r_item.high_power && !r_last_hp) begin
                    n_kick_pending = 1'b1;
                end
                if (!r_pwm_running) begin
                    n_pwm_running = 1'b1;
                    n_mark        = '0;
                    n_phase       = '0;
                    n_kick_cnt    = '0;
                end
                n_duty_out = r_duty;
                if (n_kick_pending) begin
                    n_level    = 1'b1;
                    n_kick     = 1'b1;
                    n_kick_cnt = n_kick_cnt + 1'b1;
                    if (n_kick_cnt >= KICK_TICKS) begin
                        n_kick_pending = 1'b0;
                        n_kick_cnt     = '0;
                        n_phase        = '0;
                    end
                end else begin
                    if (n_phase == '0) begin
                        n_mark = r_duty;
                    end
                    n_level   = DUTY_W'(n_phase) < n_mark;
                    phase_sum = {1'b0, n_phase} + 1'b1;
                    if (phase_sum >= (PHASE_W + 1)'(PWM_PERIOD)) begin
                        n_phase = '0;
                    end else begin
                        n_phase = phase_sum[PHASE_W-1:0];
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (start_div) begin
            r_item <= i_q_item;
            r_num  <= NUM_W'(delta) * NUM_W'(PWM_PERIOD);
            r_div  <= div_prod[DIV_W-1:0];
            r_rem  <= '0;
            r_cnt  <= DCNT_W'(NUM_W);
            r_duty <= (i_q_item.cls == CLS_PWM) ? PWM_PERIOD : '0;
        end else if (div_step) begin
            r_rem <= rem_nx[DIV_W-1:0];
            r_num <= quo_nx;
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == DCNT_W'(1)) begin
                r_duty <= quo_clamped;
            end
        end
        if (load_out) begin
            r_out_level <= n_level;
            r_out_duty  <= n_duty_out;
            r_out_kick  <= n_kick;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_out_valid    <= 1'b0;
            r_pwm_running  <= 1'b0;
            r_kick_pending <= 1'b1;
            r_kick_cnt     <= '0;
            r_phase        <= '0;
            r_mark         <= '0;
            r_last_hp      <= 1'b1;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid    <= 1'b1;
                r_pwm_running  <= n_pwm_running;
                r_kick_pending <= n_kick_pending;
                r_kick_cnt     <= n_kick_cnt;
                r_phase        <= n_phase;
                r_mark         <= n_mark;
                r_last_hp      <= n_last_hp;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_fan_level  = r_out_level;
    assign o_duty_ticks = r_out_duty;
    assign o_kicking    = r_out_kick;

endmodule

// ===== hw/rtl/fan_pwm_temperature_controller_core.sv =====
// Path: an accepted item is written into the queue, taken by the back end in ST_IDLE,
// run through ST_DIV (a 17-step restoring divider) if proportional with a nonzero on_temp,
// and loaded into the one-result output register in ST_EMIT once that register is free.
// The back end takes no new item from the queue until the last one has left ST_EMIT.
// Reset: i_rst_n is synchronous and active low; it empties the queue, clears the
// output valid flag and loads the fan state and both configuration registers.
`include "assert_macros.svh"

module fan_pwm_temperature_controller_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic signed [fptc_pkg::TEMP_W-1:0] i_temperature,
    input  logic                              i_high_power,
    input  logic                              i_cfg_we,
    input  logic [fptc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [fptc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic                              o_fan_level,
    output logic [fptc_pkg::DUTY_W-1:0]       o_duty_ticks,
    output logic                              o_kicking
);
    import fptc_pkg::*;

    t_queue_item front_item;
    t_queue_item queue_item;
    logic        push;
    logic        queue_full;
    logic        queue_valid;
    logic        pop;

    fptc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_temperature (i_temperature),
        .i_high_power  (i_high_power),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_queue_full  (queue_full),
        .o_push        (push),
        .o_item        (front_item)
    );

    fptc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (queue_full),
        .o_valid (queue_valid),
        .o_item  (queue_item),
        .i_pop   (pop)
    );

    fptc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (queue_valid),
        .i_q_item     (queue_item),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_fan_level  (o_fan_level),
        .o_duty_ticks (o_duty_ticks),
        .o_kicking    (o_kicking)
    );

    `ASSERT_IMPLIES(a_duty_range, i_clk, i_rst_n, o_valid && o_duty_ticks != '0, o_duty_ticks >= MIN_DUTY && o_duty_ticks <= PWM_PERIOD)
    `ASSERT_IMPLIES(a_kick_drives_pin, i_clk, i_rst_n, o_valid && o_kicking, o_fan_level)
    `ASSERT_IMPLIES(a_kick_only_in_pwm, i_clk, i_rst_n, o_valid && o_duty_ticks == '0, !o_kicking)
    `ASSERT_ALWAYS(a_no_push_when_full, i_clk, i_rst_n, !(push && queue_full))

endmodule

// ===== tb/tb_fan_pwm_temperature_controller_core.sv =====
`timescale 1ns / 1ps

module tb_fan_pwm_temperature_controller_core;

    localparam int TEMP_W = fptc_pkg::TEMP_W;
    localparam int DUTY_W = fptc_pkg::DUTY_W;
    localparam int IDX_W  = fptc_pkg::CFG_IDX_W;
    localparam int DATA_W = fptc_pkg::CFG_DATA_W;

    localparam int PERIOD     = fptc_pkg::PWM_PERIOD;
    localparam int KICK_LEN   = fptc_pkg::KICK_TICKS;
    localparam int DUTY_FLOOR = fptc_pkg::MIN_DUTY;
    localparam int KICK_MOD   = 1 << fptc_pkg::KICK_W;

    localparam logic [IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    localparam logic MODE_PWM  = 1'b0;
    localparam logic MODE_FULL = 1'b1;

    localparam int DRAIN_CYCLES = 30;
    localparam int CYCLE_LIMIT  = 6_000_000;
    localparam int KICK_PHASE_ITEMS = 375;

    typedef struct packed {
        logic              level;
        logic [DUTY_W-1:0] duty;
        logic              kick;
    } t_fan_tick;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_valid = 1'b0;
    logic                     o_stall;
    logic signed [TEMP_W-1:0] i_temperature = '0;
    logic                     i_high_power = 1'b0;
    logic                     i_cfg_we = 1'b0;
    logic [IDX_W-1:0]         i_cfg_idx = '0;
    logic [DATA_W-1:0]        i_cfg_data = '0;
    logic                     o_valid;
    logic                     i_stall = 1'b0;
    logic                     o_fan_level;
    logic [DUTY_W-1:0]        o_duty_ticks;
    logic                     o_kicking;

    t_fan_tick expected_ticks[$];
    int        mismatches = 0;
    int        cycle_count = 0;
    int        idle_level = 0;
    int        hold_request = 0;
    int        stall_left = 0;

    int unsigned on_temp_cfg;
    logic        mode_cfg;
    logic        fan_running;
    logic        kick_armed;
    int unsigned kick_count;
    int unsigned pwm_phase;
    int unsigned pwm_mark;
    logic        prev_high_power;

    fan_pwm_temperature_controller_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_temperature (i_temperature),
        .i_high_power  (i_high_power),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_fan_level   (o_fan_level),
        .o_duty_ticks  (o_duty_ticks),
        .o_kicking     (o_kicking)
    );

    always #1 i_clk = ~i_clk;

    function automatic int unsigned on_time_for(int t, int unsigned on);
        int k;
        int q;
        if (on == 0) begin
            return PERIOD;
        end
        if (t < 40) begin
            k = 4;
        end else if (t < 50) begin
            k = 3;
        end else if (t < 60) begin
            k = 2;
        end else begin
            k = 1;
        end
        q = ((t - int'(on)) * PERIOD) / (int'(on) * k);
        if (q <= DUTY_FLOOR) begin
            q = DUTY_FLOOR;
        end
        if (q >= PERIOD) begin
            q = PERIOD;
        end
        return q;
    endfunction

    function automatic t_fan_tick predict_fan_tick(logic signed [TEMP_W-1:0] temp_in,
                                                   logic hp);
        t_fan_tick   r;
        int          t;
        int unsigned on_time;
        r = '0;
        t = temp_in;
        if (t < int'(on_temp_cfg)) begin
            fan_running = 1'b0;
            kick_armed  = 1'b1;
            kick_count  = 0;
            pwm_phase   = 0;
        end else begin
            if (hp != prev_high_power) begin
                if (hp) begin
                    kick_armed = 1'b1;
                end
                prev_high_power = hp;
            end
            if (mode_cfg == MODE_FULL) begin
                fan_running = 1'b0;
                kick_armed  = 1'b1;
                r.level     = 1'b1;
            end else begin
                if (!fan_running) begin
                    fan_running = 1'b1;
                    pwm_mark    = 0;
                    pwm_phase   = 0;
                    kick_count  = 0;
                end
                on_time = on_time_for(t, on_temp_cfg);
                r.duty  = on_time[DUTY_W-1:0];
                if (kick_armed) begin
                    r.level    = 1'b1;
                    r.kick     = 1'b1;
                    kick_count = (kick_count + 1) % KICK_MOD;
                    if (kick_count >= KICK_LEN) begin
                        kick_armed = 1'b0;
                        kick_count = 0;
                        pwm_phase  = 0;
                    end
                end else begin
                    if (pwm_phase == 0) begin
                        pwm_mark = on_time;
                    end
                    r.level   = (pwm_phase < pwm_mark);
                    pwm_phase = pwm_phase + 1;
                    if (pwm_phase >= PERIOD) begin
                        pwm_phase = 0;
                    end
                end
            end
        end
        return r;
    endfunction

    function automatic int unsigned idle_len(int level);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (level == 0) begin
            return 0;
        end
        if (level == 1) begin
            return (r < 80) ? 0 : $urandom_range(1, 2);
        end
        if (r < 55) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 96) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [TEMP_W-1:0] pick_temperature(int unsigned on);
        int t;
        if ($urandom_range(0, 9) < 2) begin
            return TEMP_W'($urandom_range(0, (1 << TEMP_W) - 1));
        end
        t = int'(on) + int'($urandom_range(0, 70)) - 6;
        if (t > 255) begin
            t = 255;
        end
        return TEMP_W'(t);
    endfunction

    function automatic logic signed [TEMP_W-1:0] pick_warm(int unsigned on);
        return TEMP_W'(int'(on) + int'($urandom_range(0, 255 - on)));
    endfunction

    always @(posedge i_clk) begin
        t_fan_tick want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_ticks.size() == 0) begin
                $display("%0t: result with none expected: level %0b duty %0d kicking %0b",
                         $time, o_fan_level, o_duty_ticks, o_kicking);
                mismatches++;
            end else begin
                want = expected_ticks.pop_front();
                if (o_fan_level !== want.level) begin
                    $display("%0t: fan_level expected %0b actual %0b",
                             $time, want.level, o_fan_level);
                    mismatches++;
                end
                if (o_duty_ticks !== want.duty) begin
                    $display("%0t: duty_ticks expected %0d actual %0d",
                             $time, want.duty, o_duty_ticks);
                    mismatches++;
                end
                if (o_kicking !== want.kick) begin
                    $display("%0t: kicking expected %0b actual %0b",
                             $time, want.kick, o_kicking);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_request != 0) begin
            stall_left   = hold_request;
            hold_request = 0;
        end
        if (stall_left == 0) begin
            stall_left = idle_len(idle_level);
        end
        if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left--;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic send_item(input logic signed [TEMP_W-1:0] temp, input logic hp);
        int unsigned gap;
        gap = idle_len(idle_level);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_temperature <= temp;
        i_high_power  <= hp;
        do @(posedge i_clk); while (o_stall);
        expected_ticks.push_back(predict_fan_tick(temp, hp));
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (expected_ticks.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            fptc_pkg::CFG_FAN_ON_TEMP: on_temp_cfg = 32'(data);
            fptc_pkg::CFG_FAN_MODE:    mode_cfg = data[0];
            default: ;
        endcase
    endtask

    task automatic test_full_on_defaults();
        idle_level = 0;
        send_item(29, 1'b1);
        send_item(30, 1'b0);
        send_item(-256, 1'b1);
        send_item(255, 1'b1);
    endtask

    task automatic test_on_time_bands();
        idle_level = 1;
        write_reg(fptc_pkg::CFG_FAN_MODE, {6'd0, MODE_PWM});
        send_item(30, 1'b1);
        send_item(39, 1'b1);
        send_item(40, 1'b1);
        send_item(49, 1'b1);
        send_item(50, 1'b1);
        send_item(59, 1'b1);
        send_item(60, 1'b1);
        send_item(61, 1'b1);
        send_item(255, 1'b1);
        send_item(70, 1'b0);
        send_item(70, 1'b1);
        send_item(0, 1'b1);
    endtask

    task automatic test_register_edges();
        idle_level = 2;
        write_reg(fptc_pkg::CFG_FAN_ON_TEMP, 7'd0);
        send_item(-1, 1'b1);
        send_item(0, 1'b1);
        write_reg(fptc_pkg::CFG_FAN_ON_TEMP, 7'd127);
        send_item(126, 1'b1);
        send_item(127, 1'b1);
        send_item(255, 1'b0);
        write_reg(fptc_pkg::CFG_FAN_ON_TEMP, 7'd1);
        write_reg(CFG_SPARE_2, 7'd0);
        write_reg(CFG_SPARE_3, 7'h7F);
        send_item(1, 1'b1);
        send_item(20, 1'b1);
    endtask

    // A long unbroken run of warm proportional items keeps the kick-start counting,
    // then a high-power re-entry and a cold item restart it.
    task automatic test_kick_and_period();
        int unsigned on;
        idle_level = 1;
        on = $urandom_range(20, 60);
        write_reg(fptc_pkg::CFG_FAN_ON_TEMP, DATA_W'(on));
        write_reg(fptc_pkg::CFG_FAN_MODE, {6'h3F, MODE_PWM});
        repeat (KICK_PHASE_ITEMS) send_item(pick_warm(on), 1'b1);
        send_item(pick_warm(on), 1'b0);
        send_item(pick_warm(on), 1'b1);
        repeat (5) send_item(pick_warm(on), 1'b1);
        send_item(TEMP_W'(int'(on) - 1), 1'b1);
        repeat (5) send_item(pick_warm(on), 1'b1);
    endtask

    task automatic test_backpressure();
        idle_level   = 0;
        hold_request = 400;
        repeat (40) send_item(pick_temperature(on_temp_cfg), 1'($urandom_range(0, 1)));
        wait_drained();
    endtask

    task automatic test_random_traffic();
        int unsigned on;
        int unsigned sel;
        logic        hp;
        hp = 1'($urandom_range(0, 1));
        for (int p = 0; p < 10; p++) begin
            sel = $urandom_range(0, 5);
            case (sel)
                0: on = 0;
                1: on = 1;
                2: on = 127;
                3: on = 100;
                default: on = $urandom_range(1, 100);
            endcase
            write_reg(fptc_pkg::CFG_FAN_ON_TEMP, DATA_W'(on));
            write_reg(fptc_pkg::CFG_FAN_MODE,
                      {6'($urandom_range(0, 63)), ($urandom_range(0, 3) == 0) ? MODE_FULL
                                                                            : MODE_PWM});
            if (p % 4 == 3) begin
                write_reg((p % 8 == 3) ? CFG_SPARE_2 : CFG_SPARE_3,
                          DATA_W'($urandom_range(0, 127)));
            end
            idle_level = p % 3;
            repeat (150) begin
                if ($urandom_range(0, 19) == 0) begin
                    hp = ~hp;
                end
                send_item(pick_temperature(on), hp);
            end
        end
    endtask

    initial begin
        on_temp_cfg     = fptc_pkg::ON_TEMP_RESET;
        mode_cfg        = fptc_pkg::FAN_MODE_RESET;
        fan_running     = 1'b0;
        kick_armed      = 1'b1;
        kick_count      = 0;
        pwm_phase       = 0;
        pwm_mark        = 0;
        prev_high_power = 1'b1;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_full_on_defaults();
        test_on_time_bands();
        test_register_edges();
        test_kick_and_period();
        test_backpressure();
        test_random_traffic();
        wait_drained();
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
